/* src/lmt_pkg.sv */
// lmt_pkg: shared types and codes for the longest match tokenizer
// no dependencies; compiled first
package lmt_pkg;

  // at most this many result words per input word
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    OP_VOCAB_BYTE = 2'd0,
    OP_VOCAB_END  = 2'd1,
    OP_TEXT       = 2'd2,
    OP_DECODE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TOKEN  = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LS_STORED   = 2'd0,
    LS_EMPTY    = 2'd1,
    LS_FULL     = 2'd2,
    LS_TOO_LONG = 2'd3
  } load_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_VEND, S_TPRE, S_APPEND, S_TCHK, S_TEND,
    S_MSTART, S_MLEN, S_MLENW, S_MRD, S_MCMP, S_MDONE, S_MTOK, S_SHIFT,
    S_DSTART, S_DLEN, S_DRD, S_DBYTE, S_DEMPTY
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_VBYTE, DP_VEND, DP_APPEND, DP_MSTART, DP_LEN_RD,
    DP_LEN_SKIP, DP_LEN_TAKE, DP_VB_RD, DP_CMP_NEXT, DP_CMP_HIT, DP_MDONE,
    DP_TOK, DP_SHIFT, DP_PEND_FLUSH, DP_DSTART, DP_DBYTE, DP_DEMPTY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic eot;
    logic fill_zero;
    logic fill_full;
    logic len_ok;
    logic e_end;
    logic cmp_eq;
    logic i_last;
    logic dec_last;
    logic best_zero;
    logic rem_last;
    logic tok_full;
    logic pend_valid;
    logic id_ok;
    logic out_free;
  } sts_t;

endpackage

/* src/lmt_if.sv */
// lmt_in_if / lmt_out_if: valid-ready channels for input and result words
// depends on lmt_pkg
interface lmt_in_if;
  import lmt_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       end_of_text;
  logic [8:0] token_id;
  modport source (output valid, operation, byte_value, end_of_text, token_id,
                  input ready);
  modport sink (input valid, operation, byte_value, end_of_text, token_id,
                output ready);
endinterface

interface lmt_out_if;
  import lmt_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] token_out;
  logic [7:0] byte_out;
  logic [1:0] load_status;
  logic       last_of_run;
  modport source (output valid, kind, token_out, byte_out, load_status, last_of_run,
                  input ready);
  modport sink (input valid, kind, token_out, byte_out, load_status, last_of_run,
                output ready);
endinterface

/* src/lmt_ram.sv */
// lmt_ram: generic single write, single read RAM with registered read data
// no dependencies
module lmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* src/lmt_ctrl.sv */
// lmt_ctrl: sequencer for load, encode match scan and decode
// depends on lmt_pkg
module lmt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lmt_pkg::sts_t sts,
  output lmt_pkg::ctl_t ctl
);
  import lmt_pkg::*;

  state_t state_r, state_nxt;
  logic   pre_r, pre_nxt;   // match run before the text byte goes in

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pre_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pre_r   <= pre_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pre_nxt   = pre_r;
    in_ready  = 1'b0;
    ctl.op    = DP_NOP;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op    = DP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_VOCAB_BYTE: begin
            ctl.op    = DP_VBYTE;
            state_nxt = S_IDLE;
          end
          OP_VOCAB_END: state_nxt = S_VEND;
          OP_TEXT:      state_nxt = S_TPRE;
          OP_DECODE:    state_nxt = S_DSTART;
          default:      state_nxt = S_IDLE;
        endcase
      end
      S_VEND: begin
        if (sts.out_free) begin
          ctl.op    = DP_VEND;
          state_nxt = S_IDLE;
        end
      end
      S_TPRE: begin
        if (sts.fill_full) begin
          pre_nxt   = 1'b1;
          state_nxt = S_MSTART;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        ctl.op    = DP_APPEND;
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (!sts.fill_zero && (sts.fill_full || sts.eot)) begin
          state_nxt = S_MSTART;
        end else begin
          state_nxt = S_TEND;
        end
      end
      S_TEND: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          ctl.op    = DP_PEND_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      S_MSTART: begin
        ctl.op    = DP_MSTART;
        state_nxt = S_MLEN;
      end
      S_MLEN: begin
        if (sts.e_end) begin
          state_nxt = S_MDONE;
        end else begin
          ctl.op    = DP_LEN_RD;
          state_nxt = S_MLENW;
        end
      end
      S_MLENW: begin
        if (sts.len_ok) begin
          ctl.op    = DP_LEN_TAKE;
          state_nxt = S_MRD;
        end else begin
          ctl.op    = DP_LEN_SKIP;
          state_nxt = S_MLEN;
        end
      end
      S_MRD: begin
        ctl.op    = DP_VB_RD;
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        if (!sts.cmp_eq) begin
          ctl.op    = DP_LEN_SKIP;
          state_nxt = S_MLEN;
        end else if (sts.i_last) begin
          ctl.op    = DP_CMP_HIT;
          state_nxt = S_MLEN;
        end else begin
          ctl.op    = DP_CMP_NEXT;
          state_nxt = S_MRD;
        end
      end
      S_MDONE: begin
        ctl.op    = DP_MDONE;
        state_nxt = sts.best_zero ? S_SHIFT : S_MTOK;
      end
      S_MTOK: begin
        if (sts.tok_full) begin
          state_nxt = S_SHIFT;
        end else if (!sts.pend_valid || sts.out_free) begin
          ctl.op    = DP_TOK;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ctl.op = DP_SHIFT;
        if (sts.rem_last) begin
          if (pre_r) begin
            pre_nxt   = 1'b0;
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_TCHK;
          end
        end
      end
      S_DSTART: begin
        if (sts.id_ok) begin
          ctl.op    = DP_DSTART;
          state_nxt = S_DLEN;
        end else begin
          state_nxt = S_DEMPTY;
        end
      end
      S_DLEN: begin
        ctl.op    = DP_LEN_TAKE;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        ctl.op    = DP_VB_RD;
        state_nxt = S_DBYTE;
      end
      S_DBYTE: begin
        if (sts.out_free) begin
          ctl.op    = DP_DBYTE;
          state_nxt = sts.dec_last ? S_IDLE : S_DRD;
        end
      end
      S_DEMPTY: begin
        if (sts.out_free) begin
          ctl.op    = DP_DEMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* src/lmt_dp.sv */
// lmt_dp: vocabulary stores, text buffer, match registers and result register
// depends on lmt_pkg, lmt_if and lmt_ram
module lmt_dp #(
  parameter int NUM_ENTRIES   = 256,
  parameter int MAX_TOKEN_LEN = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    in_operation,
  input  logic [7:0]    in_byte_value,
  input  logic          in_end_of_text,
  input  logic [8:0]    in_token_id,
  input  lmt_pkg::ctl_t ctl,
  output lmt_pkg::sts_t sts,
  lmt_out_if.source     out_port
);
  import lmt_pkg::*;

  localparam int LW  = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CUW = $clog2(MAX_TOKEN_LEN + 2);
  localparam int CW  = $clog2(NUM_ENTRIES + 1);
  localparam int EW  = $clog2(NUM_ENTRIES);
  localparam int BW  = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam int AW  = $clog2(NUM_ENTRIES * MAX_TOKEN_LEN);
  localparam int IDW = (CW > 9) ? CW : 9;
  localparam logic [AW-1:0] M_AW = AW'(MAX_TOKEN_LEN);

  // latched input word
  op_t         op_r;
  logic [7:0]  byte_r;
  logic        eot_r;
  logic [8:0]  id_r;

  // load state
  logic [CW-1:0]  count_r;
  logic [CUW-1:0] cursor_r;
  logic [AW-1:0]  load_base_r;

  // text buffer
  logic [7:0]    buf_r [MAX_TOKEN_LEN];
  logic [LW-1:0] fill_r;

  // scan state
  logic [CW-1:0]    e_r;
  logic [AW-1:0]    base_r;
  logic [LW-1:0]    i_r;
  logic [LW-1:0]    cur_len_r;
  logic [LW-1:0]    best_len_r;
  logic [EW-1:0]    best_id_r;
  logic [LW-1:0]    rem_r;
  logic [CNT_W-1:0] tok_cnt_r;
  logic             pend_valid_r;
  logic [7:0]       pend_tok_r;

  // result register
  logic       out_valid_r;
  logic [1:0] kind_r;
  logic [7:0] token_r;
  logic [7:0] byte_out_r;
  logic [1:0] status_r;
  logic       last_r;

  logic [IDW-1:0] id_ext;
  logic           out_free;
  logic           out_load;
  logic           vb_we, len_we;
  logic [AW-1:0]  vb_waddr;
  logic [EW-1:0]  len_raddr;
  logic [7:0]     vb_rdata;
  logic [LW-1:0]  len_rdata;
  logic           len_re, vb_re;

  assign id_ext   = IDW'(id_r);
  assign out_free = !out_valid_r || out_port.ready;

  // a new result word goes into the register this cycle
  assign out_load = (ctl.op == DP_VEND) || (ctl.op == DP_DBYTE)
                    || (ctl.op == DP_DEMPTY) || (ctl.op == DP_PEND_FLUSH)
                    || ((ctl.op == DP_TOK) && pend_valid_r);

  assign vb_we    = (ctl.op == DP_VBYTE) && (count_r < CW'(NUM_ENTRIES))
                    && (cursor_r < CUW'(MAX_TOKEN_LEN));
  assign vb_waddr = load_base_r + AW'(cursor_r);
  assign vb_re    = (ctl.op == DP_VB_RD);

  assign len_we    = (ctl.op == DP_VEND) && (cursor_r != '0)
                     && (cursor_r <= CUW'(MAX_TOKEN_LEN))
                     && (count_r < CW'(NUM_ENTRIES));
  assign len_re    = (ctl.op == DP_LEN_RD) || (ctl.op == DP_DSTART);
  assign len_raddr = (ctl.op == DP_DSTART) ? id_ext[EW-1:0] : e_r[EW-1:0];

  lmt_ram #(.WIDTH(8), .DEPTH(NUM_ENTRIES * MAX_TOKEN_LEN)) u_vocab_ram (
    .clk   (clk),
    .we    (vb_we),
    .waddr (vb_waddr),
    .wdata (byte_r),
    .re    (vb_re),
    .raddr (base_r + AW'(i_r)),
    .rdata (vb_rdata)
  );

  lmt_ram #(.WIDTH(LW), .DEPTH(NUM_ENTRIES)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (count_r[EW-1:0]),
    .wdata (LW'(cursor_r)),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      cursor_r     <= '0;
      load_base_r  <= '0;
      fill_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_port.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.op)
        DP_LATCH: begin
          op_r         <= op_t'(in_operation);
          byte_r       <= in_byte_value;
          eot_r        <= in_end_of_text;
          id_r         <= in_token_id;
          tok_cnt_r    <= '0;
          pend_valid_r <= 1'b0;
        end
        DP_VBYTE: begin
          if (cursor_r <= CUW'(MAX_TOKEN_LEN)) begin
            cursor_r <= cursor_r + CUW'(1);
          end
        end
        DP_VEND: begin
          out_valid_r <= 1'b1;
          kind_r      <= KIND_STATUS;
          token_r     <= '0;
          byte_out_r  <= '0;
          last_r      <= 1'b1;
          if (cursor_r == '0) begin
            status_r <= LS_EMPTY;
          end else if (cursor_r > CUW'(MAX_TOKEN_LEN)) begin
            status_r <= LS_TOO_LONG;
          end else if (count_r >= CW'(NUM_ENTRIES)) begin
            status_r <= LS_FULL;
          end else begin
            status_r    <= LS_STORED;
            count_r     <= count_r + CW'(1);
            load_base_r <= load_base_r + M_AW;
          end
          cursor_r <= '0;
        end
        DP_APPEND: begin
          buf_r[fill_r[BW-1:0]] <= byte_r;
          fill_r                <= fill_r + LW'(1);
        end
        DP_MSTART: begin
          e_r        <= '0;
          base_r     <= '0;
          best_len_r <= '0;
          best_id_r  <= '0;
        end
        DP_LEN_SKIP: begin
          e_r    <= e_r + CW'(1);
          base_r <= base_r + M_AW;
        end
        DP_LEN_TAKE: begin
          cur_len_r <= len_rdata;
          i_r       <= '0;
        end
        DP_CMP_NEXT: i_r <= i_r + LW'(1);
        DP_CMP_HIT: begin
          best_len_r <= cur_len_r;
          best_id_r  <= e_r[EW-1:0];
          e_r        <= e_r + CW'(1);
          base_r     <= base_r + M_AW;
        end
        DP_MDONE: rem_r <= (best_len_r == '0) ? LW'(1) : best_len_r;
        DP_TOK: begin
          // hand the older token on, it is no longer the last one
          if (pend_valid_r) begin
            out_valid_r <= 1'b1;
            kind_r      <= KIND_TOKEN;
            token_r     <= pend_tok_r;
            byte_out_r  <= '0;
            status_r    <= '0;
            last_r      <= 1'b0;
          end
          pend_valid_r <= 1'b1;
          pend_tok_r   <= 8'(best_id_r);
          tok_cnt_r    <= tok_cnt_r + CNT_W'(1);
        end
        DP_SHIFT: begin
          for (int k = 0; k < MAX_TOKEN_LEN - 1; k++) begin
            buf_r[k] <= buf_r[k + 1];
          end
          fill_r <= fill_r - LW'(1);
          rem_r  <= rem_r - LW'(1);
        end
        DP_PEND_FLUSH: begin
          out_valid_r  <= 1'b1;
          kind_r       <= KIND_TOKEN;
          token_r      <= pend_tok_r;
          byte_out_r   <= '0;
          status_r     <= '0;
          last_r       <= 1'b1;
          pend_valid_r <= 1'b0;
        end
        DP_DSTART: base_r <= AW'(id_ext[EW-1:0]) * M_AW;
        DP_DBYTE: begin
          out_valid_r <= 1'b1;
          kind_r      <= KIND_BYTE;
          token_r     <= '0;
          byte_out_r  <= vb_rdata;
          status_r    <= '0;
          last_r      <= sts.dec_last;
          i_r         <= i_r + LW'(1);
        end
        DP_DEMPTY: begin
          out_valid_r <= 1'b1;
          kind_r      <= KIND_EMPTY;
          token_r     <= '0;
          byte_out_r  <= '0;
          status_r    <= '0;
          last_r      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.eot        = eot_r;
    sts.fill_zero  = (fill_r == '0);
    sts.fill_full  = (fill_r >= LW'(MAX_TOKEN_LEN));
    sts.len_ok     = (len_rdata != '0) && (len_rdata <= fill_r)
                     && (len_rdata >= best_len_r);
    sts.e_end      = (e_r >= count_r);
    sts.cmp_eq     = (vb_rdata == buf_r[i_r[BW-1:0]]);
    sts.i_last     = (i_r == cur_len_r - LW'(1));
    sts.dec_last   = sts.i_last || (32'(i_r) == 32'(RESULT_LIMIT - 1));
    sts.best_zero  = (best_len_r == '0);
    sts.rem_last   = (rem_r == LW'(1));
    sts.tok_full   = (tok_cnt_r >= CNT_W'(RESULT_LIMIT));
    sts.pend_valid = pend_valid_r;
    sts.id_ok      = (id_ext < IDW'(count_r));
    sts.out_free   = out_free;
  end

  assign out_port.valid       = out_valid_r;
  assign out_port.kind        = kind_r;
  assign out_port.token_out   = token_r;
  assign out_port.byte_out    = byte_out_r;
  assign out_port.load_status = status_r;
  assign out_port.last_of_run = last_r;
endmodule

/* src/longest_match_tokenizer_unit.sv */
// longest_match_tokenizer_unit: greedy longest match tokenizer, top level
// depends on lmt_pkg, lmt_if, lmt_ram, lmt_ctrl and lmt_dp
//
//   channel   direction  handshake          word
//   in_port   sink       valid / ready      operation, byte_value, end_of_text, token_id
//   out_port  source     valid / ready      kind, token_out, byte_out, load_status,
//                                           last_of_run
//
// one input word is worked on at a time; a vocab byte is latched, then written; an entry
// close waits for a free result register; an encode match decision walks the
// entry table, reading each length and comparing the bytes of entries that fit,
// then the buffer shift drops the consumed bytes; the entry-by-entry scan through
// the length and byte RAMs sets the rate; decode reads the length, then emits each byte
// rst_n clears the entry count, cursor and buffer fill; stores need no clearing pass
// a stalled result register holds the sequencer only when it has a new word to emit
module longest_match_tokenizer_unit #(
  parameter int NUM_ENTRIES   = 256,
  parameter int MAX_TOKEN_LEN = 16
) (
  input logic        clk,
  input logic        rst_n,
  lmt_in_if.sink     in_port,
  lmt_out_if.source  out_port
);
  import lmt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer: decides the next datapath step from status flags
  lmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_port.valid),
    .in_ready (in_port.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath: vocabulary RAMs, text buffer, scan registers, result register
  lmt_dp #(
    .NUM_ENTRIES   (NUM_ENTRIES),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_port.operation),
    .in_byte_value  (in_port.byte_value),
    .in_end_of_text (in_port.end_of_text),
    .in_token_id    (in_port.token_id),
    .ctl            (ctl),
    .sts            (sts),
    .out_port       (out_port)
  );

`ifndef SYNTHESIS
  // an accepted word always keeps the sequencer busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_port.valid && in_port.ready |=> !in_port.ready)
    else $error("input taken twice in a row");

  // a held-back token never survives into idle
  a_no_pending_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pend_valid |-> !in_port.ready)
    else $error("pending token left behind");

  // result register is only loaded when it is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == DP_VEND || ctl.op == DP_DBYTE || ctl.op == DP_DEMPTY ||
     ctl.op == DP_PEND_FLUSH) |-> sts.out_free)
    else $error("result overwritten");
`endif
endmodule

/* tb/lmt_checker.sv */
`timescale 1ns / 100ps
// lmt_checker: watches both channels of the tokenizer, predicts result words and compares
// depends on lmt_pkg and lmt_if
module lmt_checker #(
  parameter int NUM_ENTRIES   = 256,
  parameter int MAX_TOKEN_LEN = 16
) (
  input  logic clk,
  input  logic rst_n,
  lmt_in_if    in_mon,
  lmt_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   words_seen
);
  import lmt_pkg::*;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   tok;
    logic [7:0]   byt;
    load_status_t st;
    logic         last;
  } res_word_t;

  logic [7:0] vocab_mem [NUM_ENTRIES*MAX_TOKEN_LEN];
  int         entry_len [NUM_ENTRIES];
  int         n_entries;
  int         cursor;
  logic [7:0] text_buf [MAX_TOKEN_LEN];
  int         fill;
  res_word_t  expected_words [$];
  res_word_t  run_words [$];

  function automatic void push_word(kind_t k, logic [7:0] t, logic [7:0] b,
                                    load_status_t s);
    res_word_t w;
    if (run_words.size() >= RESULT_LIMIT) return;
    w.kind = k; w.tok = t; w.byt = b; w.st = s; w.last = 1'b0;
    run_words.insert(run_words.size(), w);
  endfunction

  // one longest match decision at the head of the text buffer
  function automatic void match_head();
    int best_len, best_id, ln;
    bit same;
    best_len = 0;
    best_id  = 0;
    for (int e = 0; e < n_entries; e++) begin
      ln = entry_len[e];
      if (ln == 0 || ln > fill || ln < best_len) continue;
      same = 1;
      for (int i = 0; i < ln; i++)
        if (vocab_mem[e*MAX_TOKEN_LEN+i] != text_buf[i]) same = 0;
      if (same) begin
        best_len = ln;
        best_id  = e;
      end
    end
    if (best_len == 0) best_len = 1;
    else push_word(KIND_TOKEN, 8'(best_id), 8'd0, LS_STORED);
    for (int i = 0; i + best_len < fill; i++) text_buf[i] = text_buf[i+best_len];
    fill -= best_len;
  endfunction

  function automatic void predict_word(op_t op, logic [7:0] b, logic eot, logic [8:0] id);
    load_status_t s;
    run_words.delete();
    case (op)
      OP_VOCAB_BYTE: begin
        if (n_entries < NUM_ENTRIES && cursor < MAX_TOKEN_LEN)
          vocab_mem[n_entries*MAX_TOKEN_LEN+cursor] = b;
        if (cursor <= MAX_TOKEN_LEN) cursor++;
      end
      OP_VOCAB_END: begin
        if (cursor == 0) s = LS_EMPTY;
        else if (cursor > MAX_TOKEN_LEN) s = LS_TOO_LONG;
        else if (n_entries >= NUM_ENTRIES) s = LS_FULL;
        else begin
          entry_len[n_entries] = cursor;
          n_entries++;
          s = LS_STORED;
        end
        cursor = 0;
        push_word(KIND_STATUS, 8'd0, 8'd0, s);
      end
      OP_TEXT: begin
        if (fill >= MAX_TOKEN_LEN) match_head();
        text_buf[fill] = b;
        fill++;
        while (fill > 0 && (fill >= MAX_TOKEN_LEN || eot)) match_head();
      end
      default: begin
        if (id < n_entries)
          for (int i = 0; i < entry_len[id]; i++)
            push_word(KIND_BYTE, 8'd0, vocab_mem[id*MAX_TOKEN_LEN+i], LS_STORED);
        if (run_words.size() == 0) push_word(KIND_EMPTY, 8'd0, 8'd0, LS_STORED);
      end
    endcase
    if (run_words.size() > 0) run_words[run_words.size()-1].last = 1'b1;
    foreach (run_words[i]) expected_words.insert(expected_words.size(), run_words[i]);
  endfunction

  res_word_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      n_entries  = 0;
      cursor     = 0;
      fill       = 0;
      fail_count = 0;
      words_seen = 0;
      expected_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_word(op_t'(in_mon.operation), in_mon.byte_value, in_mon.end_of_text,
                     in_mon.token_id);
      if (out_mon.valid && out_mon.ready) begin
        words_seen++;
        got.kind = kind_t'(out_mon.kind);
        got.tok  = out_mon.token_out;
        got.byt  = out_mon.byte_out;
        got.st   = load_status_t'(out_mon.load_status);
        got.last = out_mon.last_of_run;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: kind %0d tok %0d byte %0d st %0d last %0d",
                     got.kind, got.tok, got.byt, got.st, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp kind %0d tok %0d byte %0d st %0d last %0d, ",
                        "got kind %0d tok %0d byte %0d st %0d last %0d"},
                       want.kind, want.tok, want.byt, want.st, want.last,
                       got.kind, got.tok, got.byt, got.st, got.last);
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

/* tb/tb_longest_match_tokenizer_unit.sv */
`timescale 1ns / 100ps
// tb_longest_match_tokenizer_unit: stimulus and verdict for the tokenizer
// depends on lmt_pkg, lmt_if, lmt_checker and the unit itself
module tb_longest_match_tokenizer_unit;
  import lmt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, words_seen;
  int   words_sent = 0;
  bit   no_gaps = 0;   // phases with back-to-back traffic

  lmt_in_if  in_ch ();
  lmt_out_if out_ch ();

  longest_match_tokenizer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch)
  );

  lmt_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .words_seen (words_seen)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls, changed at the falling edge only
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // hand one word over; valid drops after acceptance unless the next word follows at once
  task automatic send_word(op_t op, logic [7:0] b, logic eot, logic [8:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation   = op;
    in_ch.byte_value  = b;
    in_ch.end_of_text = eot;
    in_ch.token_id    = id;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // whole vocab entry followed by its close
  task automatic load_entry(string s);
    for (int i = 0; i < s.len(); i++)
      send_word(OP_VOCAB_BYTE, s[i], 1'($urandom_range(0, 1)), 9'($urandom));
    send_word(OP_VOCAB_END, 8'($urandom), 1'($urandom_range(0, 1)), 9'($urandom));
  endtask

  task automatic encode_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_word(OP_TEXT, s[i], i == s.len() - 1, 9'($urandom));
  endtask

  // random text over a small alphabet so that matches are common
  function automatic string random_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h61, 8'h64)))};
    return s;
  endfunction

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    int r;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_VOCAB_BYTE;
    in_ch.byte_value  = 8'd0;
    in_ch.end_of_text = 1'b0;
    in_ch.token_id    = 9'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: prefixes, a duplicate for the tie rule, empty and over-long entries
    load_entry("a");
    load_entry("ab");
    load_entry("abc");
    load_entry("ab");                           // duplicate, later index wins
    send_word(OP_VOCAB_END, 8'd0, 1'b0, 9'd0);  // empty entry skipped
    load_entry(string'({8'h01, 8'hff, "bcdabcdabcdabc"})); // exactly max length, high and low bytes
    load_entry("abcdabcdabcdabcdx");            // one byte too long, dropped
    encode_text("abcxab");                      // longest match, unmatched byte skipped
    encode_text("abababababababababa");         // buffer fills before end of text
    send_word(OP_DECODE, 8'd0, 1'b0, 9'd5);     // one past the full-length entry, out of range
    send_word(OP_DECODE, 8'd0, 1'b0, 9'd511);   // out of range
    send_word(OP_DECODE, 8'd0, 1'b0, 9'd0);
    drain();

    // random: mostly well-formed loads, texts and decodes, some noise
    while (words_sent < 225) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) load_entry(random_text($urandom_range(1, 4)));
      else if (r < 55) encode_text(random_text($urandom_range(1, 20)));
      else if (r < 80) send_word(OP_DECODE, 8'($urandom), 1'($urandom_range(0, 1)),
                                 9'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                         : $urandom));
      else send_word(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                     9'($urandom));
    end
    no_gaps = 0;
    in_ch.valid = 1'b0;
    drain();

    $display("sent %0d input words (directed and random); checked %0d result words",
             words_sent, words_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout with %0d result words outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
